// ===== rtl/ccpc_pkg.sv =====
// shared constants and types of the cluster component pair counter
`timescale 1ns / 1ps
`default_nettype none

package ccpc_pkg;

    localparam int CLUSTER_W       = 8;
    localparam int COMP_W          = 8;
    localparam int CELL_AW         = CLUSTER_W + COMP_W;
    localparam int CELL_DEPTH      = 1 << CELL_AW;
    localparam int COMP_DEPTH      = 1 << COMP_W;
    localparam int COUNT_W         = 25;
    localparam int TAG_W           = 16;
    localparam int ENTRY_W         = TAG_W + COUNT_W;
    localparam int TOTAL_W         = 40;
    localparam int OUTER_INC_W     = COUNT_W + 1;
    localparam int SEEN_W          = 9;
    localparam int DEF_VERTICES    = 256;
    localparam int DEF_MAX_SAMPLES = 65535;

    localparam logic [SEEN_W-1:0]  CFG_RESET = SEEN_W'(256);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SEEN_W-1:0]  SEEN_MAX  = '1;

    // one table entry: sample tag and count
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
    } t_entry;

    // vertex waiting for its table read
    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster;
        logic [COMP_W-1:0]    comp;
        logic                 last;
    } t_s1;

    // increments and status after the table update
    typedef struct packed {
        logic [COUNT_W-1:0]     inner_inc;
        logic [OUTER_INC_W-1:0] outer_inc;
        logic [TAG_W-1:0]       samples;
        logic                   err;
        logic                   limit;
    } t_s2;

endpackage

`default_nettype wire

// ===== rtl/cluster_component_pair_counter.sv =====
// cluster component pair counter: top level with tagged count tables
// pipeline: an accepted beat passes the s1 and s2 registers into the output register
// throughput: one vertex per cycle unless an output stall or the sweep holds the
//   input, set by one cell table read-modify-write per vertex with write forwarding
// reset: synchronous, active low; a clearing sweep then walks all 65536 cell table
//   entries (and the component table with it), input stalled meanwhile
`timescale 1ns / 1ps
`default_nettype none

module cluster_component_pair_counter #(
    parameter int VERTICES    = ccpc_pkg::DEF_VERTICES,
    parameter int MAX_SAMPLES = ccpc_pkg::DEF_MAX_SAMPLES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [ccpc_pkg::SEEN_W-1:0]     i_cfg_wdata,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [ccpc_pkg::CLUSTER_W-1:0]  i_cluster_index,
    input  wire logic [ccpc_pkg::COMP_W-1:0]     i_component_label,
    input  wire logic                            i_last_in_sample,
    // output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [ccpc_pkg::TOTAL_W-1:0]    o_inner_pair_total,
    output logic      [ccpc_pkg::TOTAL_W-1:0]    o_outer_pair_total,
    output logic      [ccpc_pkg::TAG_W-1:0]      o_samples_completed,
    output logic                                 o_length_error,
    output logic                                 o_limit_reached
);

    import ccpc_pkg::*;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [SEEN_W-1:0]  r_cfg;
    logic               r_clear_busy;
    logic [CELL_AW-1:0] r_clear_addr;

    logic               r_s1_valid;
    t_s1                r_s1;
    logic               r_s2_valid;
    t_s2                r_s2;
    logic               r_out_valid;

    // running state of the current sample
    logic [TAG_W-1:0]   r_sample;
    logic [SEEN_W-1:0]  r_seen;
    logic               r_err;
    logic               r_limit;

    // totals double as the output payload
    logic [TOTAL_W-1:0] r_inner;
    logic [TOTAL_W-1:0] r_outer;
    logic [TAG_W-1:0]   r_out_samples;
    logic               r_out_err;
    logic               r_out_limit;

    // last write to each table, for a read issued on the same edge
    logic               r_cfw_valid;
    logic [CELL_AW-1:0] r_cfw_addr;
    t_entry             r_cfw_data;
    logic               r_sfw_valid;
    logic [COMP_W-1:0]  r_sfw_addr;
    t_entry             r_sfw_data;

    // ------------------------------------------------------------------
    // flow control: s1 (table data back) -> s2 (increments) -> output
    // ------------------------------------------------------------------
    logic out_ready;
    logic s2_fire;
    logic s2_ready;
    logic s1_fire;
    logic s1_ready;
    logic in_accept;
    logic update;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign s2_fire   = r_s2_valid && out_ready;
    assign s2_ready  = !r_s2_valid || s2_fire;
    assign s1_fire   = r_s1_valid && s2_ready;
    assign s1_ready  = !r_s1_valid || s1_fire;
    assign in_accept = i_in_valid && s1_ready && !r_clear_busy;
    // once the sample limit is reached a vertex changes nothing
    assign update    = s1_fire && !r_limit;

    assign o_in_stall = r_clear_busy || !s1_ready;

    // ------------------------------------------------------------------
    // table memories
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] cell_rdata;
    logic [ENTRY_W-1:0] size_rdata;
    logic               tbl_we;
    logic [CELL_AW-1:0] cell_waddr;
    logic [COMP_W-1:0]  size_waddr;
    t_entry             cell_wdata;
    t_entry             size_wdata;
    logic [CELL_AW-1:0] s1_cell_addr;
    t_entry             n_cell;
    t_entry             n_size;

    assign s1_cell_addr = {r_s1.cluster, r_s1.comp};

    assign tbl_we     = r_clear_busy || update;
    assign cell_waddr = r_clear_busy ? r_clear_addr : s1_cell_addr;
    assign size_waddr = r_clear_busy ? r_clear_addr[COMP_W-1:0] : r_s1.comp;
    assign cell_wdata = r_clear_busy ? '0 : n_cell;
    assign size_wdata = r_clear_busy ? '0 : n_size;

    ccpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELL_DEPTH)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_re    (in_accept),
        .i_raddr ({i_cluster_index, i_component_label}),
        .o_rdata (cell_rdata)
    );

    ccpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (COMP_DEPTH)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (size_waddr),
        .i_wdata (size_wdata),
        .i_re    (in_accept),
        .i_raddr (i_component_label),
        .o_rdata (size_rdata)
    );

    // ------------------------------------------------------------------
    // s1: forward, tag check, increments, write back
    // ------------------------------------------------------------------
    t_entry                 cell_rd;
    t_entry                 size_rd;
    logic [COUNT_W-1:0]     x_cnt;
    logic [COUNT_W-1:0]     s_cnt;
    logic [COUNT_W-1:0]     diff;
    logic [OUTER_INC_W-1:0] outer_inc;
    logic [SEEN_W-1:0]      n_seen;
    logic [TAG_W-1:0]       n_sample;
    logic                   n_err;
    logic                   n_limit;
    logic [SEEN_W-1:0]      seen_inc;
    logic [TAG_W-1:0]       sample_inc;

    always_comb begin
        cell_rd = (r_cfw_valid && r_cfw_addr == s1_cell_addr) ? r_cfw_data
                                                              : t_entry'(cell_rdata);
        size_rd = (r_sfw_valid && r_sfw_addr == r_s1.comp) ? r_sfw_data
                                                           : t_entry'(size_rdata);
        // an entry tagged with an older sample counts as empty
        x_cnt = (cell_rd.tag == r_sample) ? cell_rd.count : '0;
        s_cnt = (size_rd.tag == r_sample) ? size_rd.count : '0;

        diff = s_cnt - x_cnt;
        // a saturated cell above its component size adds nothing outside
        outer_inc = (s_cnt >= x_cnt) ? {diff, 1'b0} : '0;

        n_cell.tag   = r_sample;
        n_cell.count = (x_cnt == COUNT_MAX) ? COUNT_MAX : x_cnt + COUNT_W'(1);
        n_size.tag   = r_sample;
        n_size.count = (s_cnt == COUNT_MAX) ? COUNT_MAX : s_cnt + COUNT_W'(1);

        seen_inc   = (r_seen == SEEN_MAX) ? SEEN_MAX : r_seen + SEEN_W'(1);
        sample_inc = r_sample + TAG_W'(1);

        n_seen   = r_seen;
        n_sample = r_sample;
        n_err    = r_err;
        n_limit  = r_limit;
        if (!r_limit) begin
            n_seen = seen_inc;
            if (r_s1.last) begin
                // sample end: length check, next tag
                n_seen   = '0;
                n_sample = sample_inc;
                if (seen_inc != r_cfg) begin
                    n_err = 1'b1;
                end
                if ({1'b0, sample_inc} >= (TAG_W + 1)'(MAX_SAMPLES)) begin
                    n_limit = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // s2 -> output: saturating totals
    // ------------------------------------------------------------------
    logic [TOTAL_W:0] inner_sum;
    logic [TOTAL_W:0] outer_sum;

    assign inner_sum = {1'b0, r_inner} + (TOTAL_W + 1)'(r_s2.inner_inc);
    assign outer_sum = {1'b0, r_outer} + (TOTAL_W + 1)'(r_s2.outer_inc);

    // ------------------------------------------------------------------
    // sequential
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= CFG_RESET;
            r_clear_busy  <= 1'b1;
            r_clear_addr  <= '0;
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_sample      <= '0;
            r_seen        <= '0;
            r_err         <= 1'b0;
            r_limit       <= 1'b0;
            r_inner       <= '0;
            r_outer       <= '0;
            r_out_samples <= '0;
            r_out_err     <= 1'b0;
            r_out_limit   <= 1'b0;
            r_cfw_valid   <= 1'b0;
            r_sfw_valid   <= 1'b0;
        end else begin
            // configuration, clamped to the vertex count
            if (i_cfg_we) begin
                if (32'(i_cfg_wdata) > VERTICES) begin
                    r_cfg <= SEEN_W'(VERTICES);
                end else begin
                    r_cfg <= i_cfg_wdata;
                end
            end

            // clearing sweep after reset
            if (r_clear_busy) begin
                r_clear_addr <= r_clear_addr + CELL_AW'(1);
                if (r_clear_addr == '1) begin
                    r_clear_busy <= 1'b0;
                end
            end

            // s1 register
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            // table forwarding and sample state
            if (r_clear_busy) begin
                r_cfw_valid <= 1'b0;
                r_sfw_valid <= 1'b0;
            end else if (update) begin
                r_cfw_valid <= 1'b1;
                r_sfw_valid <= 1'b1;
            end
            if (s1_fire) begin
                r_seen   <= n_seen;
                r_sample <= n_sample;
                r_err    <= n_err;
                r_limit  <= n_limit;
            end

            // s2 register
            if (s1_fire) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end

            // output register holds the totals
            if (s2_fire) begin
                r_out_valid   <= 1'b1;
                r_inner       <= inner_sum[TOTAL_W] ? '1 : inner_sum[TOTAL_W-1:0];
                r_outer       <= outer_sum[TOTAL_W] ? '1 : outer_sum[TOTAL_W-1:0];
                r_out_samples <= r_s2.samples;
                r_out_err     <= r_s2.err;
                r_out_limit   <= r_s2.limit;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers without reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1.cluster <= i_cluster_index;
            r_s1.comp    <= i_component_label;
            r_s1.last    <= i_last_in_sample;
        end
        if (update) begin
            r_cfw_addr <= s1_cell_addr;
            r_cfw_data <= n_cell;
            r_sfw_addr <= r_s1.comp;
            r_sfw_data <= n_size;
        end
        if (s1_fire) begin
            // a vertex past the sample limit adds nothing
            r_s2.inner_inc <= r_limit ? '0 : x_cnt;
            r_s2.outer_inc <= r_limit ? '0 : outer_inc;
            r_s2.samples   <= n_sample;
            r_s2.err       <= n_err;
            r_s2.limit     <= n_limit;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_inner_pair_total  = r_inner;
    assign o_outer_pair_total  = r_outer;
    assign o_samples_completed = r_out_samples;
    assign o_length_error      = r_out_err;
    assign o_limit_reached     = r_out_limit;

endmodule

`default_nettype wire

// ===== rtl/ccpc_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ccpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
